[hdl/mp2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants, types and helpers for the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

    // sizing
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_KERNEL  = 3;
    localparam int WIN_DEPTH   = MAX_KERNEL - 1;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = 11;
    localparam int POS_W       = 13;
    localparam int NUM_SLOTS   = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    localparam t_sample MOST_NEG = t_sample'(16'sh8000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 3'd4;

    // decoded geometry shared by the datapath
    typedef struct packed {
        logic             k3;       // kernel 3, else kernel 2
        logic             s2;       // stride 2, else stride 1
        logic             pl;
        logic             prt;
        logic             pt;
        logic             pb;
        logic [CNT_W-1:0] w_last;   // last real column
        logic [CNT_W-1:0] h_last;   // last real row
        logic [POS_W-1:0] last_sr;  // padded start row of the last window row
        logic [POS_W-1:0] last_sc;  // padded start column of the last window column
    } t_geom;

    typedef struct packed {
        t_sample pooled_value;
        logic    last_of_run;
        logic    end_of_plane;
    } t_result;

    // results caused by one input word, in delivery order
    typedef struct packed {
        logic [NUM_SLOTS-1:0]          mask;
        t_result [NUM_SLOTS-1:0]       res;
    } t_batch;

    function automatic t_sample smax(input t_sample a, input t_sample b);
        return (a > b) ? a : b;
    endfunction

endpackage

[hdl/mp2d_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_in_if
// Sample channel: one input word per handshake.
// ----------------------------------------------------------------------------
interface mp2d_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [15:0]            sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

[hdl/mp2d_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_out_if
// Pooled result channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface mp2d_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [15:0]            pooled_value;
    logic                          last_of_run;
    logic                          end_of_plane;

    modport source (output valid, output pooled_value, output last_of_run,
                    output end_of_plane, input ready);
    modport sink   (input valid, input pooled_value, input last_of_run,
                    input end_of_plane, output ready);
endinterface

[hdl/mp2d_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_cfg
// Configuration registers and decoded plane geometry.
// ----------------------------------------------------------------------------
module mp2d_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mp2d_pkg::t_geom                     o_geom
);
    import mp2d_pkg::*;

    logic [1:0]       r_kernel;
    logic [1:0]       r_stride;
    logic [CNT_W-1:0] r_width;
    logic [CNT_W-1:0] r_height;
    logic [3:0]       r_pad;

    logic [POS_W-1:0] w_eff;
    logic [POS_W-1:0] h_eff;
    logic [POS_W-1:0] pw;
    logic [POS_W-1:0] ph;
    logic [POS_W-1:0] k_val;
    logic [POS_W-1:0] dw;
    logic [POS_W-1:0] dh;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= 2'd2;
            r_stride <= 2'd2;
            r_width  <= CNT_W'(1024);
            r_height <= CNT_W'(1024);
            r_pad    <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KERNEL: r_kernel <= i_cfg_data[1:0];
                CFG_STRIDE: r_stride <= i_cfg_data[1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[CNT_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[CNT_W-1:0];
                CFG_PAD:    r_pad    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective sizes: width saturates to the line store, zero acts as one
    always_comb begin
        w_eff = POS_W'(r_width);
        if (w_eff > POS_W'(MAX_WIDTH)) w_eff = POS_W'(MAX_WIDTH);
        if (w_eff == '0) w_eff = POS_W'(1);
        h_eff = POS_W'(r_height);
        if (h_eff == '0) h_eff = POS_W'(1);
    end

    // padded sizes and the start of the last window on each axis
    always_comb begin
        o_geom.k3  = (r_kernel == 2'd3) && (MAX_KERNEL >= 3);
        o_geom.s2  = (r_stride != 2'd1);
        o_geom.pl  = r_pad[0];
        o_geom.prt = r_pad[1];
        o_geom.pt  = r_pad[2];
        o_geom.pb  = r_pad[3];
        o_geom.w_last = CNT_W'(w_eff - POS_W'(1));
        o_geom.h_last = CNT_W'(h_eff - POS_W'(1));
        k_val = o_geom.k3 ? POS_W'(3) : POS_W'(2);
        pw = w_eff + POS_W'(r_pad[0]) + POS_W'(r_pad[1]);
        ph = h_eff + POS_W'(r_pad[2]) + POS_W'(r_pad[3]);
        dw = pw - k_val;
        dh = ph - k_val;
        o_geom.last_sc = o_geom.s2 ? {dw[POS_W-1:1], 1'b0} : dw;
        o_geom.last_sr = o_geom.s2 ? {dh[POS_W-1:1], 1'b0} : dh;
    end

endmodule

[hdl/mp2d_line_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_line_store
// Two-row line memory, one entry per column holding the rows above the
// current one; read on entry to the window stage, rewritten as it leaves.
// ----------------------------------------------------------------------------
module mp2d_line_store (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [mp2d_pkg::ADDR_W-1:0]       i_rd_addr,
    input  logic                              i_wr_en,
    input  logic [mp2d_pkg::ADDR_W-1:0]       i_wr_addr,
    input  mp2d_pkg::t_sample                 i_wr_row1,   // becomes row above
    input  mp2d_pkg::t_sample                 i_wr_row2,   // becomes two rows above
    output mp2d_pkg::t_sample                 o_row1,
    output mp2d_pkg::t_sample                 o_row2
);
    import mp2d_pkg::*;

    logic [2*SAMPLE_W-1:0] mem [MAX_WIDTH];
    logic [2*SAMPLE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_row1, i_wr_row2};
        end
    end

    // registered read, with forwarding when the same column is rewritten
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rdata <= {i_wr_row1, i_wr_row2};
            end else begin
                r_rdata <= mem[i_rd_addr];
            end
        end
    end

    assign o_row1 = t_sample'(r_rdata[2*SAMPLE_W-1:SAMPLE_W]);
    assign o_row2 = t_sample'(r_rdata[SAMPLE_W-1:0]);

endmodule

[hdl/mp2d_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_window
// Position counters, input register and horizontal window; forms every
// pooled result that one input word completes.
// ----------------------------------------------------------------------------
module mp2d_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mp2d_pkg::t_geom                   i_geom,
    input  logic                              i_accept,
    input  mp2d_pkg::t_sample                 i_sample,
    input  logic                              i_go,
    input  mp2d_pkg::t_sample                 i_row1,
    input  mp2d_pkg::t_sample                 i_row2,
    output logic                              o_valid,
    output logic [mp2d_pkg::ADDR_W-1:0]       o_rd_addr,
    output logic [mp2d_pkg::ADDR_W-1:0]       o_wr_addr,
    output mp2d_pkg::t_sample                 o_wr_row1,
    output mp2d_pkg::t_sample                 o_wr_row2,
    output mp2d_pkg::t_batch                  o_batch
);
    import mp2d_pkg::*;

    logic [CNT_W-1:0] r_col_cnt;
    logic [CNT_W-1:0] r_row_cnt;
    logic [CNT_W-1:0] c_in;
    logic [CNT_W-1:0] r_in;

    logic             r_valid;
    t_sample          r_x;
    logic [CNT_W-1:0] r_c;
    logic [CNT_W-1:0] r_r;

    t_sample          r_win  [WIN_DEPTH];   // full-span column maxima
    t_sample          r_pwin [WIN_DEPTH];   // border-row column maxima

    logic             row1_ok;
    logic             row2_ok;
    logic             ok1;
    logic             ok2;
    t_sample          vf0, vf1, vf2;
    t_sample          vp0, vp1, vp2;
    t_sample          full_dc0, full_dc1, part_dc0, part_dc1;
    logic [POS_W-1:0] km1;
    logic [POS_W-1:0] sr0, sr1, sc0, sc1;
    logic             rok0, rok1, cok0, cok1;
    logic             rend0, rend1, cend0, cend1;
    logic             dr1_en, dc1_en;
    logic             col_last;

    // clamp counters to the current geometry
    always_comb begin
        c_in = (r_col_cnt > i_geom.w_last) ? i_geom.w_last : r_col_cnt;
        r_in = (r_row_cnt > i_geom.h_last) ? i_geom.h_last : r_row_cnt;
    end

    // raster position of the next word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (i_accept) begin
            if (c_in == i_geom.w_last) begin
                r_col_cnt <= '0;
                r_row_cnt <= (r_in == i_geom.h_last) ? '0 : r_in + CNT_W'(1);
            end else begin
                r_col_cnt <= c_in + CNT_W'(1);
                r_row_cnt <= r_in;
            end
        end
    end

    // input register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_go) begin
            r_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_x <= i_sample;
            r_c <= c_in;
            r_r <= r_in;
        end
    end

    assign col_last = (r_c == i_geom.w_last);

    // vertical maxima for this column and the two before it
    always_comb begin
        row1_ok = (r_r != '0);
        row2_ok = (r_r > CNT_W'(1));
        ok1     = (r_c != '0);
        ok2     = (r_c > CNT_W'(1)) && i_geom.k3;
        vf0 = r_x;
        if (row1_ok) vf0 = smax(vf0, i_row1);
        if (row2_ok && i_geom.k3) vf0 = smax(vf0, i_row2);
        vp0 = (row1_ok && i_geom.k3) ? smax(r_x, i_row1) : r_x;
        vf1 = ok1 ? r_win[0] : MOST_NEG;
        vp1 = ok1 ? r_pwin[0] : MOST_NEG;
        vf2 = ok2 ? r_win[WIN_DEPTH-1] : MOST_NEG;
        vp2 = ok2 ? r_pwin[WIN_DEPTH-1] : MOST_NEG;
        full_dc1 = i_geom.k3 ? smax(vf0, vf1) : vf0;
        full_dc0 = smax(smax(vf0, vf1), vf2);
        part_dc1 = i_geom.k3 ? smax(vp0, vp1) : vp0;
        part_dc0 = smax(smax(vp0, vp1), vp2);
    end

    // window start positions on the padded plane
    always_comb begin
        km1 = i_geom.k3 ? POS_W'(2) : POS_W'(1);
        sr0 = POS_W'(r_r) + POS_W'(i_geom.pt) - km1;
        sr1 = sr0 + POS_W'(1);
        sc0 = POS_W'(r_c) + POS_W'(i_geom.pl) - km1;
        sc1 = sc0 + POS_W'(1);
        dr1_en = (r_r == i_geom.h_last) && i_geom.pb;
        dc1_en = col_last && i_geom.prt;
        rok0 = !sr0[POS_W-1] && (!i_geom.s2 || !sr0[0]);
        rok1 = dr1_en && !sr1[POS_W-1] && (!i_geom.s2 || !sr1[0]);
        cok0 = !sc0[POS_W-1] && (!i_geom.s2 || !sc0[0]);
        cok1 = dc1_en && !sc1[POS_W-1] && (!i_geom.s2 || !sc1[0]);
        rend0 = (sr0 == i_geom.last_sr);
        rend1 = (sr1 == i_geom.last_sr);
        cend0 = (sc0 == i_geom.last_sc);
        cend1 = (sc1 == i_geom.last_sc);
    end

    // result slots: real row first, bottom border row after
    always_comb begin
        o_batch.mask = {rok1 & cok1, rok1 & cok0, rok0 & cok1, rok0 & cok0};
        o_batch.res[0].pooled_value = full_dc0;
        o_batch.res[1].pooled_value = full_dc1;
        o_batch.res[2].pooled_value = part_dc0;
        o_batch.res[3].pooled_value = part_dc1;
        o_batch.res[0].end_of_plane = rend0 & cend0;
        o_batch.res[1].end_of_plane = rend0 & cend1;
        o_batch.res[2].end_of_plane = rend1 & cend0;
        o_batch.res[3].end_of_plane = rend1 & cend1;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            o_batch.res[j].last_of_run =
                o_batch.mask[j] && ((o_batch.mask >> (j + 1)) == '0);
        end
    end

    // column maxima window, cleared at the end of each row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) r_win[i] <= MOST_NEG;
        end else if (r_valid && i_go) begin
            if (col_last) begin
                for (int i = 0; i < WIN_DEPTH; i++) r_win[i] <= MOST_NEG;
            end else begin
                for (int i = WIN_DEPTH - 1; i >= 1; i--) r_win[i] <= r_win[i-1];
                r_win[0] <= vf0;
            end
        end
    end

    // border-row maxima, masked by column position when read
    always_ff @(posedge i_clk) begin
        if (r_valid && i_go) begin
            for (int i = WIN_DEPTH - 1; i >= 1; i--) r_pwin[i] <= r_pwin[i-1];
            r_pwin[0] <= vp0;
        end
    end

    assign o_valid   = r_valid;
    assign o_rd_addr = ADDR_W'(c_in);
    assign o_wr_addr = ADDR_W'(r_c);
    assign o_wr_row1 = r_x;
    assign o_wr_row2 = i_row1;

endmodule

[hdl/mp2d_result_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2d_result_queue
// Output register holding up to four results of one input word and
// handing them out one per handshake.
// ----------------------------------------------------------------------------
module mp2d_result_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  mp2d_pkg::t_batch                  i_batch,
    output logic                              o_free,
    mp2d_out_if.source                        o_res
);
    import mp2d_pkg::*;

    logic [NUM_SLOTS-1:0]    r_mask;
    t_result [NUM_SLOTS-1:0] r_res;
    t_result                 head;
    logic                    take;
    logic                    single;

    assign take   = o_res.valid && o_res.ready;
    assign single = ((r_mask & (r_mask - NUM_SLOTS'(1))) == '0);
    assign o_free = (r_mask == '0) || (single && take);

    // pending slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_load) begin
            r_mask <= i_batch.mask;
        end else if (take) begin
            r_mask <= r_mask & (r_mask - NUM_SLOTS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_batch.res;
        end
    end

    // lowest pending slot goes first
    always_comb begin
        priority if (r_mask[0]) begin
            head = r_res[0];
        end else if (r_mask[1]) begin
            head = r_res[1];
        end else if (r_mask[2]) begin
            head = r_res[2];
        end else begin
            head = r_res[3];
        end
    end

    assign o_res.valid        = (r_mask != '0);
    assign o_res.pooled_value = head.pooled_value;
    assign o_res.last_of_run  = head.last_of_run;
    assign o_res.end_of_plane = head.end_of_plane;

endmodule

[hdl/max_pool_2d_stream_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_stream_top
// Streaming 2-D max pooling over raster-order channel planes, kernel 2 or 3,
// stride 1 or 2, optional one-sample border on each side.
// ----------------------------------------------------------------------------
// channel      dir  word                                  handshake
// i_sample_ch  in   sample_value                          valid/ready
// o_pool_ch    out  pooled_value, last_of_run, end_of_plane valid/ready
// i_cfg_*      in   register index, data                  write enable
//
// A word waits in the input register, where the line memory read lands and
// the window maxima are formed, then moves to the output register when free.
// With the output ready, words with at most one result sustain one per cycle;
// a word with more results holds the input until the output register drains.
// Reset is synchronous; the line memory needs no clearing pass.
// Output stalls back up through the output register to i_sample_ch.ready.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mp2d_in_if.sink                           i_sample_ch,
    mp2d_out_if.source                        o_pool_ch,
    input  logic                              i_cfg_we,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mp2d_pkg::*;

    t_geom             geom;
    t_batch            batch;
    logic              stage_valid;
    logic              q_free;
    logic              go;
    logic              accept;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    t_sample           wr_row1;
    t_sample           wr_row2;
    t_sample           row1;
    t_sample           row2;

    // pipeline handshake
    assign go                = stage_valid && q_free;
    assign i_sample_ch.ready = !stage_valid || go;
    assign accept            = i_sample_ch.valid && i_sample_ch.ready;

    mp2d_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom)
    );

    mp2d_line_store u_lines (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr  (rd_addr),
        .i_wr_en    (go),
        .i_wr_addr  (wr_addr),
        .i_wr_row1  (wr_row1),
        .i_wr_row2  (wr_row2),
        .o_row1     (row1),
        .o_row2     (row2)
    );

    mp2d_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_accept   (accept),
        .i_sample   (i_sample_ch.sample_value),
        .i_go       (go),
        .i_row1     (row1),
        .i_row2     (row2),
        .o_valid    (stage_valid),
        .o_rd_addr  (rd_addr),
        .o_wr_addr  (wr_addr),
        .o_wr_row1  (wr_row1),
        .o_wr_row2  (wr_row2),
        .o_batch    (batch)
    );

    mp2d_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (go),
        .i_batch    (batch),
        .o_free     (q_free),
        .o_res      (o_pool_ch)
    );

endmodule

[sim/max_pool_2d_stream_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_stream_top_test
// Self-checking bench for the streaming 2-D max pooling block. A tracker
// class models the line memories, counters and column window, predicts the
// pooled words each accepted sample causes and checks every output word in
// order. Planes are streamed whole under many kernel, stride, size and
// border settings, with random idling on both channels and one long output
// stall while the input keeps offering words.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_top_test;

    import mp2d_pkg::*;

    localparam int      HOLD_CYCLES   = 400;
    localparam int      SETTLE_CYCLES = 8;
    localparam int      RANDOM_WORDS  = 150;
    localparam t_sample TOP_SAMPLE    = 16'sh7FFF;

    // predicts pooled words and checks them against the output channel
    class pool_tracker;
        int unsigned kernel_code;
        int unsigned stride_code;
        int unsigned width_code;
        int unsigned height_code;
        int unsigned pad_bits;
        int          line_mem [2*MAX_WIDTH];
        int          col_pos;
        int          row_pos;
        int          col_max [2];
        t_result     pooled_due [$];
        int unsigned failures;

        function new();
            kernel_code = 2;
            stride_code = 2;
            width_code  = 1024;
            height_code = 1024;
            pad_bits    = 0;
            col_pos     = 0;
            row_pos     = 0;
            foreach (line_mem[i]) line_mem[i] = 0;
            col_max[0]  = MOST_NEG;
            col_max[1]  = MOST_NEG;
            failures    = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
            case (idx)
                CFG_KERNEL: kernel_code = value & 32'h3;
                CFG_STRIDE: stride_code = value & 32'h3;
                CFG_WIDTH:  width_code  = value & 32'h7FF;
                CFG_HEIGHT: height_code = value & 32'h7FF;
                CFG_PAD:    pad_bits    = value & 32'hF;
                default: ;
            endcase
        endfunction

        function int imax(input int a, input int b);
            return (a > b) ? a : b;
        endfunction

        // window maxima completed by this sample, then state update
        function void note_sample(input t_sample word);
            int      k, s, w, h, pl, pr, pt, pb;
            int      c, r, x, cur, prv, ph, pw, oh, ow, sr, sc, v, i, dr, dc;
            int      vf [3];
            int      vp [3];
            bit      ok [3];
            t_result res;
            t_result batch [$];
            k  = (kernel_code == 3) ? 3 : 2;
            s  = (stride_code == 1) ? 1 : 2;
            w  = width_code;
            h  = height_code;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            if (w < 1) w = 1;
            if (h < 1) h = 1;
            pl = pad_bits & 1;
            pr = (pad_bits >> 1) & 1;
            pt = (pad_bits >> 2) & 1;
            pb = (pad_bits >> 3) & 1;
            c  = (col_pos > w - 1) ? w - 1 : col_pos;
            r  = (row_pos > h - 1) ? h - 1 : row_pos;
            x  = word;
            cur = (r % 2) * MAX_WIDTH;
            prv = ((r % 2) ^ 1) * MAX_WIDTH;

            // vertical maxima: full span and span used by a bottom border row
            for (i = 0; i < 3; i++) begin
                vf[i] = MOST_NEG;
                vp[i] = MOST_NEG;
                ok[i] = 1'b0;
            end
            ok[0] = 1'b1;
            vf[0] = x;
            vp[0] = x;
            if (r >= 1) vf[0] = imax(vf[0], line_mem[prv + c]);
            if (k == 3 && r >= 2) vf[0] = imax(vf[0], line_mem[cur + c]);
            if (k == 3 && r >= 1) vp[0] = imax(vp[0], line_mem[prv + c]);
            for (i = 1; i < k; i++) begin
                if (c >= i) begin
                    ok[i] = 1'b1;
                    vf[i] = col_max[i - 1];
                    vp[i] = line_mem[cur + c - i];
                    if (k == 3 && r >= 1) vp[i] = imax(vp[i], line_mem[prv + c - i]);
                end
            end

            ph = h + pt + pb;
            pw = w + pl + pr;
            oh = (ph >= k) ? (ph - k) / s + 1 : 0;
            ow = (pw >= k) ? (pw - k) / s + 1 : 0;

            // real row first, then bottom border row; real column before right border
            for (dr = 0; dr < 2; dr++) begin
                if (dr == 0 || (r == h - 1 && pb == 1)) begin
                    sr = r + pt + dr - (k - 1);
                    if (sr >= 0 && (sr % s) == 0) begin
                        for (dc = 0; dc < 2; dc++) begin
                            if (dc == 0 || (c == w - 1 && pr == 1)) begin
                                sc = c + pl + dc - (k - 1);
                                if (sc >= 0 && (sc % s) == 0) begin
                                    v = MOST_NEG;
                                    for (i = 0; i < k - dc; i++)
                                        if (ok[i]) v = imax(v, dr ? vp[i] : vf[i]);
                                    res.pooled_value = t_sample'(v);
                                    res.last_of_run  = 1'b0;
                                    res.end_of_plane = (sr / s == oh - 1) && (sc / s == ow - 1);
                                    batch.push_back(res);
                                end
                            end
                        end
                    end
                end
            end
            if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
            foreach (batch[j]) pooled_due.push_back(batch[j]);

            // shift column window, store sample, advance raster position
            col_max[1]        = col_max[0];
            col_max[0]        = vf[0];
            line_mem[cur + c] = x;
            if (c >= w - 1) begin
                col_pos    = 0;
                col_max[0] = MOST_NEG;
                col_max[1] = MOST_NEG;
                row_pos    = (r >= h - 1) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        function void check_pooled(input t_result got);
            t_result want;
            if (pooled_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected pooled word: value %0d last %0b eop %0b",
                             got.pooled_value, got.last_of_run, got.end_of_plane);
                return;
            end
            want = pooled_due.pop_front();
            if (got.pooled_value !== want.pooled_value ||
                got.last_of_run !== want.last_of_run ||
                got.end_of_plane !== want.end_of_plane) begin
                failures++;
                if (failures <= 10)
                    $display("pooled word mismatch: want %0d/%0b/%0b got %0d/%0b/%0b",
                             want.pooled_value, want.last_of_run, want.end_of_plane,
                             got.pooled_value, got.last_of_run, got.end_of_plane);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mp2d_in_if  sample_ch ();
    mp2d_out_if pool_ch ();

    pool_tracker tracker;
    int          src_max_gap  = 18;
    int          snk_max_gap  = 18;
    bit          hold_request = 1'b0;

    max_pool_2d_stream_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_pool_ch   (pool_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // hang guard
    initial begin
        #30_000_000;
        $display("max_pool_2d_stream_top_test: errors");
        $finish;
    end

    // output side: random stalls, one long hold-off on request
    initial begin : result_sink
        int      gap_left;
        int      hold_left;
        t_result got;
        pool_ch.ready <= 1'b0;
        gap_left  = 0;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pool_ch.valid === 1'b1 && pool_ch.ready === 1'b1) begin
                got.pooled_value = pool_ch.pooled_value;
                got.last_of_run  = pool_ch.last_of_run;
                got.end_of_plane = pool_ch.end_of_plane;
                tracker.check_pooled(got);
                gap_left = $urandom_range(0, snk_max_gap);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pool_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                pool_ch.ready <= 1'b0;
            end else begin
                pool_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        tracker.set_reg(idx, value);
    endtask

    task automatic set_geometry(input int k_code, input int s_code, input int w_code,
                                input int h_code, input int pad);
        write_reg(CFG_KERNEL, k_code);
        write_reg(CFG_STRIDE, s_code);
        write_reg(CFG_WIDTH, w_code);
        write_reg(CFG_HEIGHT, h_code);
        write_reg(CFG_PAD, pad);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one sample word, after a random gap
    task automatic send_sample(input t_sample word);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= word;
        @(posedge i_clk);
        while (sample_ch.ready !== 1'b1) @(posedge i_clk);
        tracker.note_sample(word);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 7))
            0:       return MOST_NEG;
            1:       return TOP_SAMPLE;
            default: return t_sample'($urandom);
        endcase
    endfunction

    // a whole plane of random samples at the given size codes
    task automatic stream_plane(input int w_code, input int h_code, output int words);
        int w;
        int h;
        w = (w_code > MAX_WIDTH) ? MAX_WIDTH : ((w_code < 1) ? 1 : w_code);
        h = (h_code < 1) ? 1 : h_code;
        words = w * h;
        repeat (words) send_sample(rand_sample());
    endtask

    // idle the input, let every expected word arrive, then allow the pipe to empty
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (tracker.pooled_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int k_code;
        int s_code;
        int w_code;
        int h_code;
        int pad;
        int planes;
        int words;
        int random_words;
        tracker = new();
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= CFG_KERNEL;
        i_cfg_data             <= '0;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two-by-two plane, kernel 2 stride 2, sample extremes
        set_geometry(2, 2, 2, 2, 0);
        send_sample(TOP_SAMPLE);
        send_sample(MOST_NEG);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        settle();

        // kernel 3 stride 1 with all four borders: the last corner word gives four results
        set_geometry(3, 1, 3, 3, 15);
        send_sample(MOST_NEG);
        send_sample(MOST_NEG);
        send_sample(MOST_NEG);
        send_sample(16'sd1);
        send_sample(MOST_NEG);
        send_sample(TOP_SAMPLE);
        send_sample(-16'sd2);
        send_sample(16'sd5);
        send_sample(MOST_NEG);
        settle();

        // odd codes: kernel 0 and stride 3 act as 2, zero size acts as 1
        set_geometry(0, 3, 0, 0, 15);
        send_sample(16'sh5555);
        settle();

        // padded plane smaller than the kernel: no result at all
        set_geometry(1, 1, 1, 1, 0);
        send_sample(-16'sh2AAB);
        settle();

        // kernel 3 stride code 0 with a top border only
        set_geometry(3, 0, 3, 2, 4);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(16'sd7);
        send_sample(MOST_NEG);
        send_sample(16'sd99);
        send_sample(-16'sd3);
        settle();

        // random geometries with small planes
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            k_code = $urandom_range(0, 3);
            s_code = $urandom_range(0, 3);
            w_code = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
            h_code = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            pad    = $urandom_range(0, 15);
            src_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 18;
            snk_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 18;
            set_geometry(k_code, s_code, w_code, h_code, pad);
            planes = $urandom_range(1, 2);
            repeat (planes) begin
                stream_plane(w_code, h_code, words);
                random_words += words;
            end
            settle();
        end

        // back to back input under a long output stall at the start
        src_max_gap = 0;
        snk_max_gap = 0;
        set_geometry(3, 1, 6, 2, 15);
        hold_request = 1'b1;
        stream_plane(6, 2, words);
        settle();

        if (tracker.failures == 0 && tracker.pooled_due.size() == 0) begin
            $display("max_pool_2d_stream_top_test: clean");
        end else begin
            $display("max_pool_2d_stream_top_test: errors");
        end
        $finish;
    end

endmodule

[max_pool_2d_stream_top.f]
hdl/mp2d_pkg.sv
hdl/mp2d_in_if.sv
hdl/mp2d_out_if.sv
hdl/mp2d_cfg.sv
hdl/mp2d_line_store.sv
hdl/mp2d_window.sv
hdl/mp2d_result_queue.sv
hdl/max_pool_2d_stream_top.sv
sim/max_pool_2d_stream_top_test.sv
